@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/lppd_pkg.sv @@
// Types and constants of the length-prefixed packet deframer.
package lppd_pkg;

  localparam int unsigned HeaderBytes = 9;
  localparam int unsigned FlagPos     = 4;
  localparam int unsigned LenBytes    = 4;
  localparam logic [6:0]  MinReset    = 7'd13;

  typedef enum logic [1:0] {
    REGION_HEADER  = 2'd0,
    REGION_NAME    = 2'd1,
    REGION_BODY    = 2'd2,
    REGION_DISCARD = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_TOO_SHORT    = 2'd1,
    STATUS_LEN_MISMATCH = 2'd2,
    STATUS_NAME_LONG    = 2'd3
  } status_e;

endpackage

@@ rtl/core/lppd_if.sv @@
// Valid/ready channel interfaces for the deframer input and result beats.
interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lppd_out_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              out_byte;
  lppd_pkg::region_e       region;
  logic                    packet_done;
  lppd_pkg::status_e       status;
  logic signed [7:0]       header_flag;
  logic signed [31:0]      name_length;
  logic [31:0]             declared_length;

  modport source (
    output valid, output out_byte, output region, output packet_done, output status,
    output header_flag, output name_length, output declared_length, input ready
  );
  modport sink (
    input valid, input out_byte, input region, input packet_done, input status,
    input header_flag, input name_length, input declared_length, output ready
  );
endinterface

@@ rtl/core/length_prefixed_packet_deframer.sv @@
// Length-prefixed packet deframer: header assembly, payload tagging, end status.
//
// in_i carries one packet byte per beat with last_byte on the final beat.
// out_o returns exactly one beat per input beat: the byte, its region tag
// (header, name, body, discarded), the header fields assembled so far and,
// on the last beat, packet_done with the packet status.
// cfg_we_i/cfg_wdata_i write min_packet_bytes; write it only while idle.
// A result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless stalled; the header parse, payload
// offset and status compares all sit between the input port and the result register.
// in_i.ready is high while the result register is empty or being drained,
// so a stalled receiver holds the result and blocks the input until it is taken.
// The byte counter saturates at all ones on very long packets.
// Reset clears the counter and header words, empties the result register
// and loads min_packet_bytes with 13.
`include "assert_macros.svh"

module length_prefixed_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  lppd_in_if.sink     in_i,
  lppd_out_if.source  out_o
);
  import lppd_pkg::*;

  logic [6:0]  min_q;
  logic [31:0] pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  flag_q, flag_d;
  logic [31:0] name_q, name_d;
  logic        out_valid_q;
  logic        in_fire;
  logic        first, sat, name_neg;
  logic [31:0] off, count, minimum;
  region_e     region_d;
  status_e     status_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign first = (pos_q == '0);
  assign sat   = &pos_q;

  always_comb begin
    len_d  = first ? '0 : len_q;
    flag_d = first ? '0 : flag_q;
    name_d = first ? '0 : name_q;
    if (pos_q < 32'(LenBytes)) begin
      len_d = len_d | ({24'd0, in_i.data_byte} << {pos_q[1:0], 3'b000});
    end else if (pos_q == 32'(FlagPos)) begin
      flag_d = in_i.data_byte;
    end else if (pos_q < 32'(HeaderBytes)) begin
      name_d = name_d | ({24'd0, in_i.data_byte} << {2'(pos_q[1:0] - 2'd1), 3'b000});
    end
  end

  assign name_neg = name_d[31];
  assign off      = pos_q - 32'(HeaderBytes);
  assign count    = sat ? pos_q : pos_q + 32'd1;
  assign minimum  = (min_q < 7'(HeaderBytes)) ? 32'(HeaderBytes) : {25'd0, min_q};

  always_comb begin
    region_d = REGION_HEADER;
    if (pos_q >= 32'(HeaderBytes)) begin
      priority if (name_neg) begin
        region_d = REGION_DISCARD;
      end else if (off < name_d) begin
        region_d = REGION_NAME;
      end else begin
        region_d = REGION_BODY;
      end
    end
  end

  always_comb begin
    status_d = STATUS_OK;
    if (in_i.last_byte) begin
      priority if (count < minimum) begin
        status_d = STATUS_TOO_SHORT;
      end else if (len_d[31] || (len_d != count)) begin
        status_d = STATUS_LEN_MISMATCH;
      end else if (!name_neg && (name_d > (count - 32'(HeaderBytes)))) begin
        status_d = STATUS_NAME_LONG;
      end else begin
        status_d = STATUS_OK;
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (in_i.last_byte) begin
      pos_d = '0;
    end else if (!sat) begin
      pos_d = pos_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinReset;
    end else if (cfg_we_i) begin
      min_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      flag_q <= '0;
      name_q <= '0;
    end else if (in_fire) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      flag_q <= flag_d;
      name_q <= name_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_o.out_byte        <= in_i.data_byte;
      out_o.region          <= region_d;
      out_o.packet_done     <= in_i.last_byte;
      out_o.status          <= status_d;
      out_o.header_flag     <= flag_d;
      out_o.name_length     <= name_d;
      out_o.declared_length <= len_d;
    end
  end

  assign out_o.valid = out_valid_q;

  `ASSERT_RST(a_status_only_done, clk_i, rst_ni, (out_o.valid && !out_o.packet_done) |-> (out_o.status == STATUS_OK), "status set on a beat that is not the last")
  `ASSERT_RST(a_pos_advance, clk_i, rst_ni, (in_fire && !in_i.last_byte && !sat) |=> (pos_q == $past(pos_q) + 32'd1), "byte counter did not advance")
  `ASSERT_RST(a_pos_restart, clk_i, rst_ni, (in_fire && in_i.last_byte) |=> (pos_q == '0), "byte counter not cleared after last beat")
  `ASSERT_ANY(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid, "result valid during reset")

endmodule
